/* rtl/fic_pkg.sv */
package fic_pkg;

  localparam int DATA_W = 32;
  localparam int VIEW_W = 4;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam int DEFAULT_NUM_VIEWS = 16;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  localparam logic [DATA_W-1:0] RECOVERY_MASK_RESET = 32'h0000_0001;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY_MASK = 1'b0;

  localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_GEN = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_BEGIN = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PRESENT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 3'd4;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_GEN = 3'd1;
  localparam logic [OP_W-1:0] OP_BEGIN = 3'd2;
  localparam logic [OP_W-1:0] OP_PRESENT = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;
  localparam logic [OP_W-1:0] OP_NOP = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_VIEW = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_PRESENT = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [VIEW_W-1:0] view;
    logic [DATA_W-1:0] reasons;
    logic [DATA_W-1:0] doc;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] gen;
  } fic_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic found;
    logic [DATA_W-1:0] reasons;
    logic [DATA_W-1:0] doc;
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] gen;
    logic pending;
  } fic_result_t;

endpackage

/* rtl/fic_front.sv */
module fic_front #(
  parameter int NUM_VIEWS = fic_pkg::DEFAULT_NUM_VIEWS,
  parameter int VALUE_WIDTH = fic_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic [fic_pkg::ACTION_W-1:0] action,
  input  logic [fic_pkg::VIEW_W-1:0] view_index,
  input  logic [fic_pkg::DATA_W-1:0] reason_bits,
  input  logic [fic_pkg::DATA_W-1:0] doc_revision,
  input  logic [fic_pkg::DATA_W-1:0] preview_rev,
  input  logic [fic_pkg::DATA_W-1:0] gen_value,
  output fic_pkg::fic_item_t item
);
  import fic_pkg::*;

  localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam logic [DATA_W-1:0] VMASK = DATA_W'({STORE_W{1'b1}});

  logic in_range;

  assign in_range = (32'(view_index) < NUM_VIEWS);

  always_comb begin
    item.view = view_index;
    item.reasons = reason_bits & VMASK;
    item.doc = doc_revision & VMASK;
    item.prev = preview_rev & VMASK;
    item.gen = gen_value & VMASK;
    if (!in_range) begin
      item.op = (action == ACT_PRESENT) ? OP_BAD_PRESENT : OP_BAD_VIEW;
    end else begin
      unique case (action)
        ACT_INVALIDATE: item.op = OP_INVALIDATE;
        ACT_SET_GEN: item.op = OP_SET_GEN;
        ACT_BEGIN: item.op = OP_BEGIN;
        ACT_PRESENT: item.op = OP_PRESENT;
        ACT_QUERY: item.op = OP_QUERY;
        default: item.op = OP_NOP;
      endcase
    end
  end

endmodule

/* rtl/fic_queue.sv */
module fic_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fic_pkg::fic_item_t push_item,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output fic_pkg::fic_item_t head
);
  import fic_pkg::*;

  fic_item_t entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/fic_back.sv */
module fic_back #(
  parameter int NUM_VIEWS = fic_pkg::DEFAULT_NUM_VIEWS,
  parameter int VALUE_WIDTH = fic_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic [fic_pkg::DATA_W-1:0] recovery_mask,
  input  logic head_valid,
  input  fic_pkg::fic_item_t head,
  output logic pop,
  output logic res_valid,
  output fic_pkg::fic_result_t res,
  input  logic res_stall
);
  import fic_pkg::*;

  localparam int DEPTH = (NUM_VIEWS < (1 << VIEW_W)) ? NUM_VIEWS : (1 << VIEW_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  logic [DEPTH-1:0] pend_valid;
  logic [DEPTH-1:0] gen_known;
  logic [DEPTH-1:0] shown_valid;
  logic [STORE_W-1:0] pend_reasons [DEPTH];
  logic [STORE_W-1:0] pend_doc [DEPTH];
  logic [STORE_W-1:0] pend_prev [DEPTH];
  logic [STORE_W-1:0] pend_gen [DEPTH];
  logic [STORE_W-1:0] gen_table [DEPTH];
  logic [STORE_W-1:0] shown_doc [DEPTH];
  logic [STORE_W-1:0] shown_prev [DEPTH];
  logic [STORE_W-1:0] shown_gen [DEPTH];

  logic [IDX_W-1:0] idx;
  logic pv, gk, sv;
  logic [STORE_W-1:0] preas, pdoc, pprev, pgen, gtab, sdoc, sprev;
  logic [STORE_W-1:0] in_r, in_d, in_p, in_g, mask_s;
  logic pend_we, gen_we, shown_we;
  logic pend_valid_next;
  logic [STORE_W-1:0] reasons_next, doc_next, prev_next, gen_next;
  fic_result_t res_next;

  assign idx = head.view[IDX_W-1:0];
  assign pv = pend_valid[idx];
  assign gk = gen_known[idx];
  assign sv = shown_valid[idx];
  assign preas = pend_reasons[idx];
  assign pdoc = pend_doc[idx];
  assign pprev = pend_prev[idx];
  assign pgen = pend_gen[idx];
  assign gtab = gen_table[idx];
  assign sdoc = shown_doc[idx];
  assign sprev = shown_prev[idx];
  assign in_r = head.reasons[STORE_W-1:0];
  assign in_d = head.doc[STORE_W-1:0];
  assign in_p = head.prev[STORE_W-1:0];
  assign in_g = head.gen[STORE_W-1:0];
  assign mask_s = recovery_mask[STORE_W-1:0];

  assign pop = head_valid && (!res_valid || !res_stall);

  always_comb begin
    res_next = '0;
    pend_we = 1'b0;
    gen_we = 1'b0;
    shown_we = 1'b0;
    pend_valid_next = pv;
    reasons_next = preas;
    doc_next = pdoc;
    prev_next = pprev;
    gen_next = pgen;
    case (head.op) inside
      OP_INVALIDATE: begin
        pend_we = 1'b1;
        pend_valid_next = 1'b1;
        if (!pv) begin
          reasons_next = in_r;
          doc_next = in_d;
          prev_next = in_p;
          gen_next = in_g;
        end else begin
          reasons_next = preas | in_r;
          doc_next = (in_d > pdoc) ? in_d : pdoc;
          prev_next = (in_p > pprev) ? in_p : pprev;
          gen_next = (in_g > pgen) ? in_g : pgen;
        end
      end
      OP_SET_GEN: begin
        gen_we = 1'b1;
        if (pv) begin
          pend_we = 1'b1;
          gen_next = in_g;
          reasons_next = preas | mask_s;
        end
      end
      OP_BEGIN: begin
        if (pv) begin
          res_next.found = 1'b1;
          res_next.reasons = DATA_W'(preas);
          res_next.doc = DATA_W'(pdoc);
          res_next.prev = DATA_W'(pprev);
          res_next.gen = gk ? DATA_W'(gtab) : DATA_W'(pgen);
          pend_we = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      OP_PRESENT: begin
        if (!gk || (gtab != in_g)) begin
          res_next.status = STATUS_STALE;
        end else if (sv && ((in_d < sdoc) || (in_p < sprev))) begin
          res_next.status = STATUS_INVALID;
        end else begin
          shown_we = 1'b1;
        end
      end
      OP_QUERY: begin
        if (sv) begin
          res_next.found = 1'b1;
          res_next.doc = DATA_W'(sdoc);
          res_next.prev = DATA_W'(sprev);
          res_next.gen = DATA_W'(shown_gen[idx]);
        end
      end
      OP_BAD_PRESENT: begin
        res_next.status = STATUS_INVALID;
      end
      OP_NOP, OP_BAD_VIEW: begin
      end
      default: begin
      end
    endcase
    if (head.op == OP_BAD_VIEW || head.op == OP_BAD_PRESENT) begin
      res_next.pending = 1'b0;
    end else begin
      res_next.pending = pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
      gen_known <= '0;
      shown_valid <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b1;
        if (pend_we) begin
          pend_valid[idx] <= pend_valid_next;
        end
        if (gen_we) begin
          gen_known[idx] <= 1'b1;
        end
        if (shown_we) begin
          shown_valid[idx] <= 1'b1;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
      if (pend_we) begin
        pend_reasons[idx] <= reasons_next;
        pend_doc[idx] <= doc_next;
        pend_prev[idx] <= prev_next;
        pend_gen[idx] <= gen_next;
      end
      if (gen_we) begin
        gen_table[idx] <= in_g;
      end
      if (shown_we) begin
        shown_doc[idx] <= in_d;
        shown_prev[idx] <= in_p;
        shown_gen[idx] <= in_g;
      end
    end
  end

endmodule

/* rtl/frame_invalidation_coalescer.sv */
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  action, view_index, reason_bits, doc_revision,
//                                         preview_rev, gen_value
// output    out        out_valid/out_stall status, found, out_reasons, out_doc_revision,
//                                         out_preview_rev, out_generation, pending_after
// config    in         APB write          recovery_reason_mask at byte address 0
//
// One transaction is accepted per cycle while in_stall is low. An accepted transaction waits in the
// queue until the back end pops it into the result register, which raises out_valid.
// The two stages are the queue entry and the result register; the back end reads and updates
// the view tables in the single cycle in which it takes a transaction from the queue.
// Reset clears all valid bits at once, so the block is ready in the cycle after reset.
// A stalled output holds its result; the two-entry queue then fills and raises in_stall.
module frame_invalidation_coalescer #(
  parameter int NUM_VIEWS = fic_pkg::DEFAULT_NUM_VIEWS,
  parameter int VALUE_WIDTH = fic_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [fic_pkg::ACTION_W-1:0] action,
  input  logic [fic_pkg::VIEW_W-1:0] view_index,
  input  logic [fic_pkg::DATA_W-1:0] reason_bits,
  input  logic [fic_pkg::DATA_W-1:0] doc_revision,
  input  logic [fic_pkg::DATA_W-1:0] preview_rev,
  input  logic [fic_pkg::DATA_W-1:0] gen_value,
  output logic out_valid,
  input  logic out_stall,
  output logic [fic_pkg::STATUS_W-1:0] status,
  output logic found,
  output logic [fic_pkg::DATA_W-1:0] out_reasons,
  output logic [fic_pkg::DATA_W-1:0] out_doc_revision,
  output logic [fic_pkg::DATA_W-1:0] out_preview_rev,
  output logic [fic_pkg::DATA_W-1:0] out_generation,
  output logic pending_after,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [fic_pkg::ADDR_W-1:0] paddr,
  input  logic [fic_pkg::DATA_W-1:0] pwdata,
  output logic [fic_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import fic_pkg::*;

  logic [DATA_W-1:0] recovery_mask;
  logic reg_hit;
  fic_item_t front_item;
  fic_item_t head;
  logic q_full;
  logic head_valid;
  logic pop;
  fic_result_t res;

  assign pready = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_RECOVERY_MASK);
  assign prdata = reg_hit ? recovery_mask : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_mask <= RECOVERY_MASK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      recovery_mask <= pwdata;
    end
  end

  fic_front #(
    .NUM_VIEWS(NUM_VIEWS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .action(action),
    .view_index(view_index),
    .reason_bits(reason_bits),
    .doc_revision(doc_revision),
    .preview_rev(preview_rev),
    .gen_value(gen_value),
    .item(front_item)
  );

  assign in_stall = q_full;

  fic_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_valid),
    .push_item(front_item),
    .full(q_full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  fic_back #(
    .NUM_VIEWS(NUM_VIEWS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .recovery_mask(recovery_mask),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .res_valid(out_valid),
    .res(res),
    .res_stall(out_stall)
  );

  assign status = res.status;
  assign found = res.found;
  assign out_reasons = res.reasons;
  assign out_doc_revision = res.doc;
  assign out_preview_rev = res.prev;
  assign out_generation = res.gen;
  assign pending_after = res.pending;

endmodule

/* rtl/fic_checker.sv */
module fic_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [fic_pkg::ACTION_W-1:0] action,
  input  logic [fic_pkg::VIEW_W-1:0] view_index,
  input  logic [fic_pkg::DATA_W-1:0] reason_bits,
  input  logic [fic_pkg::DATA_W-1:0] doc_revision,
  input  logic [fic_pkg::DATA_W-1:0] preview_rev,
  input  logic [fic_pkg::DATA_W-1:0] gen_value,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [fic_pkg::STATUS_W-1:0] status,
  input  logic found,
  input  logic [fic_pkg::DATA_W-1:0] out_reasons,
  input  logic [fic_pkg::DATA_W-1:0] out_doc_revision,
  input  logic [fic_pkg::DATA_W-1:0] out_preview_rev,
  input  logic [fic_pkg::DATA_W-1:0] out_generation,
  input  logic pending_after,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [fic_pkg::ADDR_W-1:0] paddr,
  input  logic [fic_pkg::DATA_W-1:0] pwdata,
  input  logic [fic_pkg::DATA_W-1:0] prdata,
  input  logic pready
);
  import fic_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output transaction dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("Output valid right after reset.");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == STATUS_OK)
    else $error("A found frame carries an error status.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("Undefined status code.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |->
      out_reasons == '0 && out_doc_revision == '0 && out_generation == '0)
    else $error("Frame fields nonzero without a found frame.");

endmodule

bind frame_invalidation_coalescer fic_checker u_fic_checker (.*);
